// ===== src/crt_sieve_solver_defines.svh =====
// ----------------------------------------------------------------------------
// CRT sieve solver assertion macros
// Shared assertion forms for the solver checker.
// ----------------------------------------------------------------------------
`ifndef CRT_SIEVE_SOLVER_DEFINES_SVH
`define CRT_SIEVE_SOLVER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/css_pkg.sv =====
// ----------------------------------------------------------------------------
// CRT sieve solver package
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int unsigned LimitWidth = 20;
  localparam logic [19:0] LimitReset = 20'd100000;

  localparam logic [1:0] ST_SOLVED   = 2'd0;
  localparam logic [1:0] ST_NOSOL    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted item
    logic first_init;  // set running value and modulus from the item
    logic seed_mod;    // start x mod modulus
    logic mod_step;    // one bit of the restoring remainder
    logic sieve_add;   // x += running modulus
    logic seed_gcd;    // start Euclid on (modulus, running modulus)
    logic gcd_seed_div;// start remainder of gcd pair
    logic gcd_step;    // one bit of the gcd remainder
    logic gcd_swap;    // a <= b, b <= remainder
    logic seed_q;      // start modulus / g
    logic q_step;      // one quotient bit
    logic seed_mul;    // start quotient * running modulus
    logic mul_step;    // one shift-add multiply step
    logic commit_val;  // running value <= x
    logic commit_mod;  // running modulus <= product
    logic clear_sys;   // clear running state after emission
    logic set_fail;
    logic [1:0] fail_code;
    logic clear_fail;
    logic capture_out; // load the output register
  } css_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic is_last;
    logic rem_match;   // remainder equals x mod modulus
    logic add_ovf;     // x + running modulus carries
    logic gcd_b_zero;
    logic gcd_a_zero;
    logic prod_ovf;    // product exceeds 32 bits
    logic [1:0] fail;
  } css_sts_t;

endpackage

// ===== src/css_datapath.sv =====
// ----------------------------------------------------------------------------
// CRT sieve solver datapath
// Running state, serial remainder/divide unit, shift-add multiplier, output.
// ----------------------------------------------------------------------------
module css_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  css_pkg::css_cmd_t cmd,
  output css_pkg::css_sts_t sts,
  input  logic [15:0]      in_remainder,
  input  logic [15:0]      in_modulus,
  input  logic             in_last,
  output logic [31:0]      out_solution,
  output logic [31:0]      out_combined_modulus,
  output logic [1:0]       out_status
);

  logic [15:0] rem_r, mod_r;
  logic        last_r;
  logic [31:0] val_r, rmod_r, x_r;
  logic [1:0]  fail_r;
  // Shared restoring divider: dividend shift register, partial remainder,
  // divisor.
  logic [31:0] dvd_r, dvd_nxt;
  logic [32:0] prem_r, prem_nxt;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic [31:0] ga_r, gb_r;
  logic [31:0] mula_r;
  logic [63:0] mulb_r, prod_r;
  logic [32:0] xsum;
  logic [31:0] sol_r, cm_r;
  logic [1:0]  st_r;

  assign trial = {prem_r[31:0], dvd_r[31]} - {1'b0, dvs_r};
  assign xsum  = {1'b0, x_r} + {1'b0, rmod_r};

  // One restoring step: shift in next dividend bit, subtract when it fits.
  always_comb begin
    prem_nxt = {prem_r[31:0], dvd_r[31]};
    dvd_nxt  = {dvd_r[30:0], 1'b0};
    if (!trial[32]) begin
      prem_nxt = trial;
      dvd_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= '0;
      rmod_r <= '0;
      fail_r <= css_pkg::ST_SOLVED;
    end else begin
      if (cmd.first_init) begin
        val_r  <= {16'd0, rem_r};
        rmod_r <= {16'd0, mod_r};
      end
      if (cmd.commit_val) val_r <= x_r;
      if (cmd.commit_mod) rmod_r <= prod_r[31:0];
      if (cmd.clear_sys) begin
        val_r  <= '0;
        rmod_r <= '0;
      end
      // A new failure code takes priority over clearing the old one.
      if (cmd.set_fail) fail_r <= cmd.fail_code;
      else if (cmd.clear_fail) fail_r <= css_pkg::ST_SOLVED;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rem_r  <= in_remainder;
      mod_r  <= in_modulus;
      last_r <= in_last;
      x_r    <= val_r;
    end
    if (cmd.sieve_add) x_r <= xsum[31:0];
    if (cmd.seed_mod) begin
      dvd_r  <= x_r;
      prem_r <= '0;
      dvs_r  <= {16'd0, mod_r};
    end
    if (cmd.seed_gcd) begin
      ga_r <= {16'd0, mod_r};
      gb_r <= rmod_r;
    end
    if (cmd.gcd_seed_div) begin
      dvd_r  <= ga_r;
      prem_r <= '0;
      dvs_r  <= gb_r;
    end
    if (cmd.gcd_swap) begin
      ga_r <= gb_r;
      gb_r <= prem_r[31:0];
    end
    if (cmd.seed_q) begin
      dvd_r  <= {16'd0, mod_r};
      prem_r <= '0;
      dvs_r  <= ga_r;
    end
    if (cmd.mod_step || cmd.gcd_step || cmd.q_step) begin
      dvd_r  <= dvd_nxt;
      prem_r <= prem_nxt;
    end
    if (cmd.seed_mul) begin
      mula_r <= dvd_r;
      mulb_r <= {32'd0, rmod_r};
      prod_r <= '0;
    end
    if (cmd.mul_step) begin
      if (mula_r[0]) prod_r <= prod_r + mulb_r;
      mula_r <= {1'b0, mula_r[31:1]};
      mulb_r <= {mulb_r[62:0], 1'b0};
    end
    if (cmd.capture_out) begin
      if (fail_r == css_pkg::ST_SOLVED) begin
        sol_r <= val_r;
        cm_r  <= rmod_r;
      end else begin
        sol_r <= '0;
        cm_r  <= '0;
      end
      st_r <= fail_r;
    end
  end

  assign sts.mod_zero   = (mod_r == 16'd0);
  assign sts.is_last    = last_r;
  assign sts.rem_match  = (prem_r[31:0] == {16'd0, rem_r});
  assign sts.add_ovf    = xsum[32];
  assign sts.gcd_b_zero = (gb_r == 32'd0);
  assign sts.gcd_a_zero = (ga_r == 32'd0);
  assign sts.prod_ovf   = (prod_r[63:32] != 32'd0);
  assign sts.fail       = fail_r;

  assign out_solution         = sol_r;
  assign out_combined_modulus = cm_r;
  assign out_status           = st_r;

endmodule

// ===== src/css_controller.sv =====
// ----------------------------------------------------------------------------
// CRT sieve solver controller
// Sequences sieve tests, Euclid, lcm division and multiply, and emission.
// ----------------------------------------------------------------------------
module css_controller #(
  parameter int unsigned LimitWidth = css_pkg::LimitWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [LimitWidth-1:0] search_limit,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output css_pkg::css_cmd_t     cmd,
  input  css_pkg::css_sts_t     sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_TEST  = 4'd3;
  localparam logic [3:0] S_GSEED = 4'd4;
  localparam logic [3:0] S_GDIV  = 4'd5;
  localparam logic [3:0] S_GSWAP = 4'd6;
  localparam logic [3:0] S_QDIV  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_LCM   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_SEED  = 4'd11;

  logic [3:0]            state_r, state_nxt;
  logic [5:0]            bit_r, bit_nxt;
  logic [LimitWidth-1:0] try_r, try_nxt;
  logic                  first_r, first_nxt;
  logic                  ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    bit_nxt    = bit_r;
    try_nxt    = try_r;
    first_nxt  = first_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_nxt = S_DISP;
        end
      end
      // Decide what the captured item does.
      S_DISP: begin
        if (first_r) begin
          first_nxt = 1'b0;
          cmd.first_init = 1'b1;
          cmd.clear_fail = 1'b1;
          if (sts.mod_zero) begin
            cmd.set_fail = 1'b1;
            cmd.fail_code = css_pkg::ST_NOSOL;
          end
          state_nxt = S_EMIT;
        end else if (sts.fail != css_pkg::ST_SOLVED) begin
          state_nxt = S_EMIT;
        end else if (sts.mod_zero) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = css_pkg::ST_NOSOL;
          state_nxt = S_EMIT;
        end else if (search_limit == '0) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = css_pkg::ST_NOSOL;
          state_nxt = S_EMIT;
        end else begin
          try_nxt = '0;
          cmd.seed_mod = 1'b1;
          bit_nxt = '0;
          state_nxt = S_MOD;
        end
      end
      // Restart the remainder on the advanced sieve value.
      S_SEED: begin
        cmd.seed_mod = 1'b1;
        bit_nxt = '0;
        state_nxt = S_MOD;
      end
      // x mod modulus, one bit a cycle.
      S_MOD: begin
        cmd.mod_step = 1'b1;
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd31) state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sts.rem_match) begin
          cmd.commit_val = 1'b1;
          state_nxt = S_GSEED;
        end else if (try_r + 1'b1 >= search_limit) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = css_pkg::ST_NOSOL;
          state_nxt = S_EMIT;
        end else if (sts.add_ovf) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = css_pkg::ST_OVERFLOW;
          state_nxt = S_EMIT;
        end else begin
          cmd.sieve_add = 1'b1;
          try_nxt = try_r + 1'b1;
          state_nxt = S_SEED;
        end
      end
      S_GSEED: begin
        cmd.seed_gcd = 1'b1;
        state_nxt = S_GSWAP;
      end
      // Euclid loop: check b, then remainder of a by b.
      S_GSWAP: begin
        if (sts.gcd_b_zero) begin
          if (sts.gcd_a_zero) begin
            cmd.set_fail = 1'b1;
            cmd.fail_code = css_pkg::ST_NOSOL;
            state_nxt = S_EMIT;
          end else begin
            cmd.seed_q = 1'b1;
            bit_nxt = '0;
            state_nxt = S_QDIV;
          end
        end else begin
          cmd.gcd_seed_div = 1'b1;
          bit_nxt = '0;
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd.gcd_step = 1'b1;
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd31) state_nxt = S_LCM;
      end
      S_LCM: begin
        cmd.gcd_swap = 1'b1;
        state_nxt = S_GSWAP;
      end
      // modulus / g, then times running modulus.
      S_QDIV: begin
        cmd.q_step = 1'b1;
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd31) begin
          state_nxt = S_MUL;
          bit_nxt = '0;
          cmd.seed_mul = 1'b0;
        end
        if (bit_r == 6'd32) cmd.q_step = 1'b0;
      end
      S_MUL: begin
        if (bit_r == 6'd0) begin
          cmd.seed_mul = 1'b1;
          bit_nxt = 6'd1;
        end else if (bit_r == 6'd33) begin
          if (sts.prod_ovf) begin
            cmd.set_fail = 1'b1;
            cmd.fail_code = css_pkg::ST_OVERFLOW;
          end else begin
            cmd.commit_mod = 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          cmd.mul_step = 1'b1;
          bit_nxt = bit_r + 6'd1;
        end
      end
      // Emit on last, then reset the system.
      S_EMIT: begin
        if (sts.is_last) begin
          cmd.capture_out = 1'b1;
          ovalid_nxt = 1'b1;
          cmd.clear_sys = 1'b1;
          cmd.clear_fail = 1'b1;
          first_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bit_r    <= '0;
      try_r    <= '0;
      first_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bit_r    <= bit_nxt;
      try_r    <= try_nxt;
      first_r  <= first_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== src/crt_sieve_solver.sv =====
// Sieve tests and Euclid steps run on the serial 32-bit remainder unit, the lcm
// divide on it and the multiply on the shift-add unit; a first item goes straight
// from accept to emission. One item at a time: a new item waits until one is done.
// A waiting result blocks the next item until it is taken.
// Reset (rst_n low, synchronous) clears the system state; search_limit -> 100000.
// ----------------------------------------------------------------------------
// CRT sieve solver top level
// Solves a system of congruences by sieving; one result on the last item.
// ----------------------------------------------------------------------------
module crt_sieve_solver #(
  parameter int unsigned LimitWidth = css_pkg::LimitWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [LimitWidth-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_remainder,
  input  logic [15:0]           in_modulus,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_solution,
  output logic [31:0]           out_combined_modulus,
  output logic [1:0]            out_status
);

  logic [LimitWidth-1:0] limit_r;
  css_pkg::css_cmd_t     cmd;
  css_pkg::css_sts_t     sts;

  // Search limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitWidth'(css_pkg::LimitReset);
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  css_controller #(.LimitWidth(LimitWidth)) u_ctrl (
    .clk, .rst_n, .search_limit(limit_r), .in_valid, .in_ready,
    .out_valid, .out_ready, .cmd, .sts
  );

  css_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_remainder, .in_modulus, .in_last,
    .out_solution, .out_combined_modulus, .out_status
  );

endmodule

// ===== src/css_checker.sv =====
// ----------------------------------------------------------------------------
// CRT sieve solver checker
// Port-level properties of the solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "crt_sieve_solver_defines.svh"

module css_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_solution,
  input logic [1:0]  out_status
);

  // A failed system reports a zero solution.
  `CSS_ASSERT_IMPL(a_fail_zero, out_valid && out_status != css_pkg::ST_SOLVED,
                   out_solution == 32'd0, "failed result has nonzero solution")
  // Status code is never the unused value.
  `CSS_ASSERT_IMPL(a_status_code, out_valid, out_status != 2'd3, "bad status code")
  // No new item is taken while a result waits.
  `CSS_ASSERT_IMPL(a_no_accept_busy, out_valid, !in_ready,
                   "input accepted while result pending")
  // A stalled result holds its value.
  `CSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_solution), "result changed while stalled")

endmodule

bind crt_sieve_solver css_checker u_css_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_solution, .out_status
);
